// ===== hdl/hst_pkg.sv =====
// Shared types, constants and control structs for the hashed slot insert table.
package hst_pkg;

    localparam int TABLE_SLOTS = 2048;
    localparam int SLOT_BITS   = $clog2(TABLE_SLOTS);
    localparam int KEY_W       = 32;
    localparam int HITS_W      = 12;
    localparam int HSEL_W      = 3;
    localparam int INDEX_W     = 11;

    typedef logic [KEY_W-1:0]     key_t;
    typedef logic [SLOT_BITS-1:0] slot_t;
    typedef logic [HITS_W-1:0]    hits_t;
    typedef logic [HSEL_W-1:0]    hsel_t;
    typedef logic [INDEX_W-1:0]   slot_index_t;

    localparam hsel_t HS_FOLD = 3'd0;
    localparam hsel_t HS_MASK = 3'd1;
    localparam hsel_t HS_MIX  = 3'd2;
    localparam hsel_t HS_LIN  = 3'd3;
    localparam hsel_t HS_OFFS = 3'd4;

    localparam key_t  MIX_MULT   = 32'h045d_9f3b;
    localparam key_t  OFFSET_ADD = 32'd177573;
    localparam hits_t HITS_MAX   = '1;
    localparam slot_t SLOT_LAST  = slot_t'(TABLE_SLOTS - 1);

    typedef struct packed {
        logic load_item;
        logic mul_en;
        logic mul_step;
        logic idx_en;
        logic rd_en;
        logic commit;
        logic sweep_wr;
        logic clr_hits;
        logic load_clear;
    } hst_cmd_t;

    typedef struct packed {
        logic mode_clear;
        logic sweep_last;
        logic out_free;
    } hst_stat_t;

endpackage

// ===== hdl/hst_cmd_if.sv =====
// Input channel: valid/ready handshake carrying mode and key.
interface hst_cmd_if;
    import hst_pkg::*;

    logic valid;
    logic ready;
    logic mode;
    key_t key;

    modport source (output valid, output mode, output key, input ready);
    modport sink (input valid, input mode, input key, output ready);
endinterface

// ===== hdl/hst_result_if.sv =====
// Result channel: valid/ready handshake carrying slot, insert flag, key and hit count.
interface hst_result_if;
    import hst_pkg::*;

    logic        valid;
    logic        ready;
    slot_index_t slot_index;
    logic        inserted;
    key_t        resident_key;
    hits_t       hit_count;

    modport source (output valid, output slot_index, output inserted,
                    output resident_key, output hit_count, input ready);
    modport sink (input valid, input slot_index, input inserted,
                  input resident_key, input hit_count, output ready);
endinterface

// ===== hdl/hashed_slot_insert_table.sv =====
// Direct-mapped hash table with insert-if-empty, top level.
//
// cmd carries one transaction per item: mode 0 inserts key, mode 1 clears the
// table and the hit count. result returns exactly one transaction per item:
// slot index, inserted flag, key now held in the slot, and the hit count.
// hash_select is written through cfg_wr_en/cfg_wr_data; the user must do so only
// while the block is idle, which the block itself leaves unenforced.
// An insert passes the two rounds of the shared 32x32 multiplier, the index
// register, the registered read of the slot memory and the commit step before
// result valid; cmd.ready is high only in the idle state, so the next item is
// taken only once the last one has committed.
// A clear sweeps the occupancy bits one slot per cycle, then loads the zero
// result once the result register is free, with cmd.ready returning on the
// same edge. After reset the same sweep runs before cmd.ready rises.
// The result register holds its transaction while result.ready is low; the
// next item may be taken meanwhile and waits at its commit step until the
// register frees up.
module hashed_slot_insert_table (
    input  logic               clk,
    input  logic               rst_n,
    hst_cmd_if.sink            cmd,
    hst_result_if.source       result,
    input  logic               cfg_wr_en,
    input  hst_pkg::hsel_t     cfg_wr_data
);
    import hst_pkg::*;

    hst_cmd_t  ctl;
    hst_stat_t stat;

    hst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd.valid),
        .cmd_ready (cmd.ready),
        .stat      (stat),
        .ctl       (ctl)
    );

    hst_dpath u_dpath (
        .clk              (clk),
        .rst_n            (rst_n),
        .ctl              (ctl),
        .stat             (stat),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .item_mode        (cmd.mode),
        .item_key         (cmd.key),
        .out_valid        (result.valid),
        .out_ready        (result.ready),
        .out_slot_index   (result.slot_index),
        .out_inserted     (result.inserted),
        .out_resident_key (result.resident_key),
        .out_hit_count    (result.hit_count)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.valid && cmd.ready |=> !cmd.ready)
        else $error("cmd accepted while previous item in progress");

    a_commit_room: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.commit || ctl.load_clear |-> stat.out_free)
        else $error("result loaded over a pending transaction");

    a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.sweep_wr && (ctl.commit || ctl.rd_en)))
        else $error("slot memory sweep overlaps a lookup");

    a_insert_counts: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.inserted |-> result.hit_count != '0)
        else $error("insert reported with zero hit count");
endmodule

// ===== hdl/hst_ctrl.sv =====
// Sequencing state machine: table sweep, hash steps, lookup and commit.
module hst_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  hst_pkg::hst_stat_t stat,
    output hst_pkg::hst_cmd_t  ctl
);
    import hst_pkg::*;

    localparam logic [2:0] ST_SWEEP   = 3'd0;
    localparam logic [2:0] ST_IDLE    = 3'd1;
    localparam logic [2:0] ST_MUL1    = 3'd2;
    localparam logic [2:0] ST_MUL2    = 3'd3;
    localparam logic [2:0] ST_IDX     = 3'd4;
    localparam logic [2:0] ST_READ    = 3'd5;
    localparam logic [2:0] ST_COMMIT  = 3'd6;
    localparam logic [2:0] ST_CLR_OUT = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       clr_item_reg;
    logic       clr_item_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_SWEEP;
            clr_item_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_item_reg <= clr_item_next;
        end
    end

    assign cmd_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        clr_item_next = clr_item_reg;
        ctl           = '0;
        case (state_reg)
            ST_SWEEP:
            begin
                ctl.sweep_wr = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = clr_item_reg ? ST_CLR_OUT : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    ctl.load_item = 1'b1;
                    state_next    = ST_MUL1;
                end
            end
            ST_MUL1:
            begin
                if (stat.mode_clear)
                begin
                    ctl.clr_hits  = 1'b1;
                    clr_item_next = 1'b1;
                    state_next    = ST_SWEEP;
                end
                else
                begin
                    ctl.mul_en = 1'b1;
                    state_next = ST_MUL2;
                end
            end
            ST_MUL2:
            begin
                ctl.mul_en   = 1'b1;
                ctl.mul_step = 1'b1;
                state_next   = ST_IDX;
            end
            ST_IDX:
            begin
                ctl.idx_en = 1'b1;
                state_next = ST_READ;
            end
            ST_READ:
            begin
                ctl.rd_en  = 1'b1;
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (stat.out_free)
                begin
                    ctl.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_CLR_OUT:
            begin
                if (stat.out_free)
                begin
                    ctl.load_clear = 1'b1;
                    clr_item_next  = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule

// ===== hdl/hst_dpath.sv =====
// Datapath: hash unit, slot memory, hit counter, config register and result register.
module hst_dpath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  hst_pkg::hst_cmd_t    ctl,
    output hst_pkg::hst_stat_t   stat,
    input  logic                 cfg_wr_en,
    input  hst_pkg::hsel_t       cfg_wr_data,
    input  logic                 item_mode,
    input  hst_pkg::key_t        item_key,
    output logic                 out_valid,
    input  logic                 out_ready,
    output hst_pkg::slot_index_t out_slot_index,
    output logic                 out_inserted,
    output hst_pkg::key_t        out_resident_key,
    output hst_pkg::hits_t       out_hit_count
);
    import hst_pkg::*;

    hsel_t       hsel_reg;
    logic        mode_reg;
    key_t        key_reg;
    key_t        prod_reg;
    slot_t       idx_reg;
    logic [KEY_W:0] rd_data_reg;
    slot_t       sweep_cnt_reg;
    hits_t       hits_reg;
    hits_t       hits_next;
    logic        out_valid_reg;
    slot_index_t out_index_reg;
    logic        out_ins_reg;
    key_t        out_key_reg;
    hits_t       out_hits_reg;

    logic [KEY_W:0] slot_mem [TABLE_SLOTS];

    key_t           mul_op;
    key_t           mul_full;
    key_t           hash;
    logic           occ;
    logic           do_insert;
    logic           mem_we;
    slot_t          mem_addr;
    logic [KEY_W:0] mem_wdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hsel_reg <= HS_FOLD;
        end
        else if (cfg_wr_en)
        begin
            hsel_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_item)
        begin
            mode_reg <= item_mode;
            key_reg  <= item_key;
        end
    end

    // shared multiplier, one round per step
    assign mul_op   = ctl.mul_step ? (prod_reg ^ (prod_reg >> 16)) : (key_reg ^ (key_reg >> 16));
    assign mul_full = mul_op * MIX_MULT;

    always_ff @(posedge clk)
    begin
        if (ctl.mul_en)
        begin
            prod_reg <= mul_full;
        end
    end

    always_comb
    begin
        case (hsel_reg)
            HS_MASK: hash = key_reg;
            HS_MIX:  hash = prod_reg ^ (prod_reg >> 16);
            HS_LIN:  hash = (key_reg << 2) + key_reg + key_t'(1);
            HS_OFFS: hash = key_reg + OFFSET_ADD;
            default: hash = (key_reg >> 24) ^ (key_reg >> 16) ^ (key_reg >> 8) ^ key_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.idx_en)
        begin
            idx_reg <= hash[SLOT_BITS-1:0];
        end
    end

    // slot memory: {occupied, key}
    assign occ       = rd_data_reg[KEY_W];
    assign do_insert = ctl.commit & ~occ;
    assign mem_we    = ctl.sweep_wr | do_insert;
    assign mem_addr  = ctl.sweep_wr ? sweep_cnt_reg : idx_reg;
    assign mem_wdata = ctl.sweep_wr ? '0 : {1'b1, key_reg};

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[mem_addr] <= mem_wdata;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= slot_mem[idx_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_cnt_reg <= '0;
        end
        else if (ctl.sweep_wr)
        begin
            sweep_cnt_reg <= sweep_cnt_reg + slot_t'(1);
        end
    end

    always_comb
    begin
        hits_next = hits_reg;
        if (ctl.clr_hits)
        begin
            hits_next = '0;
        end
        else if (do_insert && (hits_reg != HITS_MAX))
        begin
            hits_next = hits_reg + hits_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hits_reg <= '0;
        end
        else
        begin
            hits_reg <= hits_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.commit || ctl.load_clear)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.commit)
        begin
            out_index_reg <= slot_index_t'(idx_reg);
            out_ins_reg   <= ~occ;
            out_key_reg   <= occ ? rd_data_reg[KEY_W-1:0] : key_reg;
            out_hits_reg  <= hits_next;
        end
        else if (ctl.load_clear)
        begin
            out_index_reg <= '0;
            out_ins_reg   <= 1'b0;
            out_key_reg   <= '0;
            out_hits_reg  <= '0;
        end
    end

    assign out_valid        = out_valid_reg;
    assign out_slot_index   = out_index_reg;
    assign out_inserted     = out_ins_reg;
    assign out_resident_key = out_key_reg;
    assign out_hit_count    = out_hits_reg;

    assign stat.mode_clear = mode_reg;
    assign stat.sweep_last = (sweep_cnt_reg == SLOT_LAST);
    assign stat.out_free   = ~out_valid_reg | out_ready;
endmodule

// ===== dv/hashed_slot_insert_table_tb.sv =====
// Testbench for hashed_slot_insert_table: directed and random insert/clear traffic with checking.
module hashed_slot_insert_table_tb;
    import hst_pkg::*;

    localparam logic  MODE_INSERT = 1'b0;
    localparam logic  MODE_CLEAR  = 1'b1;
    localparam hsel_t HS_UNUSED   = 3'd7;
    localparam int    SEG_ITEMS   = 205;
    localparam int    MAX_SHOWN   = 10;

    typedef struct {
        slot_index_t slot_index;
        logic        inserted;
        key_t        resident_key;
        hits_t       hit_count;
    } slot_result_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    hsel_t cfg_wr_data;

    hst_cmd_if    cmd_ch ();
    hst_result_if result_ch ();

    hashed_slot_insert_table dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd_ch),
        .result      (result_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // table shadow
    bit           slot_used [TABLE_SLOTS];
    key_t         slot_keys [TABLE_SLOTS];
    hits_t        hit_total;
    hsel_t        hash_sel;
    slot_result_t pending_results [$];
    key_t         recent_keys [$];

    int send_idle_pct;
    int recv_idle_pct;
    int errors;
    int n_checked;
    int n_inserts;
    int n_collisions;
    int n_clears;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic key_t hash_of(key_t k);
        key_t h;
        case (hash_sel)
            HS_MASK: h = k;
            HS_MIX:
            begin
                h = ((k >> 16) ^ k) * MIX_MULT;
                h = ((h >> 16) ^ h) * MIX_MULT;
                h = (h >> 16) ^ h;
            end
            HS_LIN:  h = k * 32'd5 + 32'd1;
            HS_OFFS: h = k + OFFSET_ADD;
            default: h = (k >> 24) ^ (k >> 16) ^ (k >> 8) ^ k;
        endcase
        return h;
    endfunction

    function automatic slot_result_t apply_item(logic mode, key_t key);
        slot_result_t r;
        slot_t        idx;
        r = '{slot_index: '0, inserted: 1'b0, resident_key: '0, hit_count: '0};
        if (mode == MODE_CLEAR)
        begin
            foreach (slot_used[i])
                slot_used[i] = 1'b0;
            hit_total = '0;
            n_clears++;
            return r;
        end
        idx = slot_t'(hash_of(key));
        if (!slot_used[idx])
        begin
            slot_used[idx] = 1'b1;
            slot_keys[idx] = key;
            if (hit_total != HITS_MAX)
                hit_total++;
            r.inserted = 1'b1;
            n_inserts++;
        end
        else
            n_collisions++;
        r.slot_index   = slot_index_t'(idx);
        r.resident_key = slot_keys[idx];
        r.hit_count    = hit_total;
        return r;
    endfunction

    task automatic send_item(logic mode, key_t key);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.mode  <= mode;
        cmd_ch.key   <= key;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        pending_results.push_back(apply_item(mode, key));
        recent_keys.push_back(key);
        if (recent_keys.size() > 32)
            void'(recent_keys.pop_front());
    endtask

    task automatic drain_results();
        cmd_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_hash_select(hsel_t sel);
        drain_results();
        repeat (4) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= sel;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        hash_sel = sel;
    endtask

    always @(posedge clk)
        result_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        slot_result_t exp_r;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                errors++;
                if (errors <= MAX_SHOWN)
                    $display("ERROR: unexpected result transaction slot=%0d key=%h",
                             result_ch.slot_index, result_ch.resident_key);
            end
            else
            begin
                exp_r = pending_results.pop_front();
                n_checked++;
                if (result_ch.slot_index !== exp_r.slot_index
                    || result_ch.inserted !== exp_r.inserted
                    || result_ch.resident_key !== exp_r.resident_key
                    || result_ch.hit_count !== exp_r.hit_count)
                begin
                    errors++;
                    if (errors <= MAX_SHOWN)
                        $display({"ERROR: result %0d exp slot=%0d ins=%b key=%h hits=%0d",
                                  " got slot=%0d ins=%b key=%h hits=%0d"},
                                 n_checked, exp_r.slot_index, exp_r.inserted,
                                 exp_r.resident_key, exp_r.hit_count,
                                 result_ch.slot_index, result_ch.inserted,
                                 result_ch.resident_key, result_ch.hit_count);
                end
            end
        end
    end

    task automatic test_default_hash();
        send_item(MODE_INSERT, 32'h0000_0000);
        send_item(MODE_INSERT, 32'hFFFF_FFFF);
        send_item(MODE_INSERT, 32'h0000_0000);
        send_item(MODE_INSERT, 32'h1234_5678);
        send_item(MODE_INSERT, 32'h8000_0000);
    endtask

    task automatic test_clear();
        send_item(MODE_CLEAR, 32'hFFFF_FFFF);
        send_item(MODE_INSERT, 32'h0000_0000);
        send_item(MODE_INSERT, 32'h0000_0000);
        send_item(MODE_CLEAR, 32'h0000_0000);
        send_item(MODE_CLEAR, 32'h5A5A_A5A5);
    endtask

    task automatic test_each_hash();
        hsel_t sels [5];
        sels = '{HS_MASK, HS_MIX, HS_LIN, HS_OFFS, HS_UNUSED};
        foreach (sels[i])
        begin
            write_hash_select(sels[i]);
            send_item(MODE_INSERT, 32'hFFFF_FFFF);
            send_item(MODE_INSERT, 32'h8000_0001);
        end
    endtask

    task automatic test_collision();
        write_hash_select(HS_MASK);
        send_item(MODE_CLEAR, 32'h0);
        send_item(MODE_INSERT, 32'd5);
        send_item(MODE_INSERT, 32'd5 + 32'd2048);
        send_item(MODE_INSERT, 32'hFFFF_F805);
        send_item(MODE_INSERT, 32'd2047);
    endtask

    task automatic run_traffic(hsel_t sel);
        int   r;
        key_t key;
        write_hash_select(sel);
        for (int n = 0; n < SEG_ITEMS; n++)
        begin
            r = $urandom_range(0, 99);
            if (r == 0)
            begin
                send_item(MODE_CLEAR, $urandom);
                continue;
            end
            if (r < 3)
                drain_results();
            r = $urandom_range(0, 99);
            if (r < 35 || recent_keys.size() == 0)
                key = $urandom;
            else if (r < 60)
                key = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
            else if (r < 85)
                key = $urandom_range(0, 4095);
            else
                key = recent_keys[$] + 32'd2048 * $urandom_range(1, 8);
            send_item(MODE_INSERT, key);
        end
    endtask

    task automatic test_random_traffic();
        send_idle_pct = 13;
        recv_idle_pct = 77;
        run_traffic(HS_MIX);
        run_traffic(HS_FOLD);
        send_idle_pct = 77;
        recv_idle_pct = 13;
        run_traffic(HS_LIN);
        run_traffic(HS_MASK);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_traffic(HS_OFFS);
        run_traffic(HS_UNUSED);
    endtask

    initial
    begin
        rst_n           = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_wr_data     = HS_FOLD;
        cmd_ch.valid    = 1'b0;
        cmd_ch.mode     = MODE_INSERT;
        cmd_ch.key      = '0;
        result_ch.ready = 1'b0;
        send_idle_pct   = 13;
        recv_idle_pct   = 77;
        hash_sel        = HS_FOLD;
        hit_total       = '0;
        errors          = 0;
        n_checked       = 0;
        n_inserts       = 0;
        n_collisions    = 0;
        n_clears        = 0;
        foreach (slot_used[i])
            slot_used[i] = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        test_default_hash();
        test_clear();
        test_each_hash();
        test_collision();
        test_random_traffic();

        drain_results();
        repeat (50) @(posedge clk);
        $display("Covered all hash selects incl. unused code, %0d inserts, %0d collisions,",
                 n_inserts, n_collisions);
        $display("%0d clears, %0d results checked under mixed backpressure",
                 n_clears, n_checked);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
